// ===== rtl/core/tmp_pkg.sv =====
package tmp_pkg;

  // Default and bounds
  localparam int unsigned MaxSizeDefault = 64;
  localparam int unsigned SizeW = 7;
  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  // Item field widths
  localparam int unsigned OpW = 3;
  localparam int unsigned IdxW = 12;
  localparam int unsigned ElemW = 16;
  localparam int unsigned AbW = 48;
  localparam int unsigned ResW = 64;
  localparam int unsigned StatW = 2;

  // Opcodes
  localparam logic [OpW-1:0] OpLoadA = 3'd0;
  localparam logic [OpW-1:0] OpLoadB = 3'd1;
  localparam logic [OpW-1:0] OpLoadC = 3'd2;
  localparam logic [OpW-1:0] OpCompute = 3'd3;
  localparam logic [OpW-1:0] OpRead = 3'd4;

  // Status codes
  localparam logic [StatW-1:0] StOk = 2'd0;
  localparam logic [StatW-1:0] StNotReady = 2'd1;
  localparam logic [StatW-1:0] StRange = 2'd2;
  localparam logic [StatW-1:0] StUnused = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_a;      // store element into A
    logic ld_b;
    logic ld_c;
    logic rd_res;    // read ABC element at the item index
    logic issue;     // start one multiply-accumulate step
    logic phase;     // 0: AB = A*B, 1: ABC = AB*C
    logic first;     // first k of a dot product
    logic last;      // last k of a dot product
    logic val_load;  // update the result value register
    logic val_mem;   // value from ABC read data, else zero
  } cmd_t;

  // Signed add clamped to 64 bits
  function automatic logic signed [ResW-1:0] sat_add64(logic signed [ResW-1:0] a,
                                                       logic signed [ResW-1:0] b);
    logic signed [ResW-1:0] s;
    s = a + b;
    if (a[ResW-1] == b[ResW-1] && s[ResW-1] != a[ResW-1]) begin
      s = a[ResW-1] ? {1'b1, {(ResW-1){1'b0}}} : {1'b0, {(ResW-1){1'b1}}};
    end
    return s;
  endfunction

  // Clamp a 64-bit value to signed 48 bits
  function automatic logic signed [AbW-1:0] sat48(logic signed [ResW-1:0] v);
    logic signed [AbW-1:0] r;
    if (v > $signed({{(ResW-AbW+1){1'b0}}, {(AbW-1){1'b1}}})) begin
      r = {1'b0, {(AbW-1){1'b1}}};
    end else if (v < $signed({{(ResW-AbW+1){1'b1}}, {(AbW-1){1'b0}}})) begin
      r = {1'b1, {(AbW-1){1'b0}}};
    end else begin
      r = v[AbW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tmp_ctrl.sv =====
module tmp_ctrl #(
  parameter int unsigned MAX_SIZE = tmp_pkg::MaxSizeDefault,
  localparam int unsigned SW = $clog2(MAX_SIZE + 1),
  localparam int unsigned IW = $clog2(MAX_SIZE)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tmp_pkg::SizeW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tmp_pkg::OpW-1:0] opcode_i,
  input  logic [tmp_pkg::IdxW-1:0] element_index_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic [tmp_pkg::StatW-1:0] status_o,
  output tmp_pkg::cmd_t cmd_o,
  output logic [SW-1:0] n_o,
  output logic [IW-1:0] i_o,
  output logic [IW-1:0] j_o,
  output logic [IW-1:0] k_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AB = 3'd1;
  localparam logic [2:0] S_AB_DRAIN = 3'd2;
  localparam logic [2:0] S_ABC = 3'd3;
  localparam logic [2:0] S_ABC_DRAIN = 3'd4;
  localparam logic [1:0] DrainLast = 2'd2;

  logic [2:0] state_q, state_d;
  logic [tmp_pkg::SizeW-1:0] size_q;
  logic ready_q, ready_d;
  logic pend_q, pend_d;
  logic ov_q, ov_d;
  logic [tmp_pkg::StatW-1:0] st_q, st_d;
  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [1:0] dr_q, dr_d;
  logic [SW-1:0] n;
  logic [2*SW-1:0] nsq;
  logic in_range, acc, k_last, j_last, i_last;

  // Size in use, clamped to 1..MAX_SIZE
  always_comb begin
    if (size_q == '0) begin
      n = SW'(1);
    end else if (32'(size_q) > 32'(MAX_SIZE)) begin
      n = SW'(MAX_SIZE);
    end else begin
      n = SW'(size_q);
    end
  end

  assign nsq = (2*SW)'(n) * (2*SW)'(n);
  assign in_range = 32'(element_index_i) < 32'(nsq);
  assign in_ready_o = (state_q == S_IDLE) && !pend_q && (!ov_q || out_ready_i);
  assign acc = in_valid_i && in_ready_o;

  assign k_last = (SW'(k_q) + SW'(1)) == n;
  assign j_last = (SW'(j_q) + SW'(1)) == n;
  assign i_last = (SW'(i_q) + SW'(1)) == n;

  // Sequencer and handshake
  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    pend_d = 1'b0;
    ov_d = ov_q && !out_ready_i;
    st_d = st_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    dr_d = dr_q;
    cmd_o = '0;
    cmd_o.phase = (state_q == S_ABC) || (state_q == S_ABC_DRAIN);
    cmd_o.first = (k_q == '0);
    cmd_o.last = k_last;

    unique case (state_q)
      S_IDLE: begin
        if (pend_q) begin
          // ABC read data is now registered
          ov_d = 1'b1;
          st_d = tmp_pkg::StOk;
          cmd_o.val_load = 1'b1;
          cmd_o.val_mem = 1'b1;
        end else if (acc) begin
          cmd_o.val_load = 1'b1;
          st_d = tmp_pkg::StOk;
          ov_d = 1'b1;
          priority if (opcode_i == tmp_pkg::OpLoadA || opcode_i == tmp_pkg::OpLoadB ||
                       opcode_i == tmp_pkg::OpLoadC) begin
            if (!in_range) begin
              st_d = tmp_pkg::StRange;
            end else begin
              cmd_o.ld_a = (opcode_i == tmp_pkg::OpLoadA);
              cmd_o.ld_b = (opcode_i == tmp_pkg::OpLoadB);
              cmd_o.ld_c = (opcode_i == tmp_pkg::OpLoadC);
            end
          end else if (opcode_i == tmp_pkg::OpCompute) begin
            ov_d = 1'b0;
            i_d = '0;
            j_d = '0;
            k_d = '0;
            state_d = S_AB;
          end else if (opcode_i == tmp_pkg::OpRead) begin
            if (!in_range) begin
              st_d = tmp_pkg::StRange;
            end else if (!ready_q) begin
              st_d = tmp_pkg::StNotReady;
            end else begin
              ov_d = 1'b0;
              cmd_o.val_load = 1'b0;
              cmd_o.rd_res = 1'b1;
              pend_d = 1'b1;
            end
          end else begin
            st_d = tmp_pkg::StOk;
          end
        end
      end
      S_AB, S_ABC: begin
        cmd_o.issue = 1'b1;
        k_d = k_q + IW'(1);
        if (k_last) begin
          k_d = '0;
          j_d = j_q + IW'(1);
          if (j_last) begin
            j_d = '0;
            i_d = i_q + IW'(1);
            if (i_last) begin
              i_d = '0;
              dr_d = '0;
              state_d = (state_q == S_AB) ? S_AB_DRAIN : S_ABC_DRAIN;
            end
          end
        end
      end
      S_AB_DRAIN, S_ABC_DRAIN: begin
        // let the last sums reach memory
        dr_d = dr_q + 2'd1;
        if (dr_q == DrainLast) begin
          if (state_q == S_AB_DRAIN) begin
            state_d = S_ABC;
          end else begin
            state_d = S_IDLE;
            ready_d = 1'b1;
            ov_d = 1'b1;
            st_d = tmp_pkg::StOk;
            cmd_o.val_load = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      size_q <= tmp_pkg::SizeReset;
      ready_q <= 1'b0;
      pend_q <= 1'b0;
      ov_q <= 1'b0;
      st_q <= tmp_pkg::StOk;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      dr_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      ready_q <= ready_d;
      pend_q <= pend_d;
      ov_q <= ov_d;
      st_q <= st_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      dr_q <= dr_d;
    end
  end

  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign n_o = n;
  assign i_o = i_q;
  assign j_o = j_q;
  assign k_o = k_q;

endmodule

// ===== rtl/core/tmp_dp.sv =====
module tmp_dp #(
  parameter int unsigned MAX_SIZE = tmp_pkg::MaxSizeDefault,
  localparam int unsigned SW = $clog2(MAX_SIZE + 1),
  localparam int unsigned IW = $clog2(MAX_SIZE),
  localparam int unsigned AW = $clog2(MAX_SIZE * MAX_SIZE),
  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE,
  localparam int unsigned PW = SW + IW + 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tmp_pkg::cmd_t cmd_i,
  input  logic [SW-1:0] n_i,
  input  logic [IW-1:0] i_i,
  input  logic [IW-1:0] j_i,
  input  logic [IW-1:0] k_i,
  input  logic [tmp_pkg::IdxW-1:0] element_index_i,
  input  logic signed [tmp_pkg::ElemW-1:0] element_value_i,
  output logic signed [tmp_pkg::ResW-1:0] read_value_o
);

  localparam int unsigned EW = tmp_pkg::ElemW;
  localparam int unsigned BW = tmp_pkg::AbW;
  localparam int unsigned RW = tmp_pkg::ResW;

  logic signed [EW-1:0] mem_a [DEPTH];
  logic signed [EW-1:0] mem_b [DEPTH];
  logic signed [EW-1:0] mem_c [DEPTH];
  logic signed [BW-1:0] mem_p [DEPTH];
  logic signed [RW-1:0] mem_f [DEPTH];

  logic [AW-1:0] idx_addr, ik_addr, kj_addr, ij_addr;
  logic [PW-1:0] ik_w, kj_w, ij_w;
  logic signed [EW-1:0] a_rd_q, b_rd_q, c_rd_q;
  logic signed [BW-1:0] p_rd_q;
  logic signed [RW-1:0] f_rd_q, val_q;
  logic s1_vld_q, s1_first_q, s1_last_q, s1_phase_q;
  logic s2_vld_q, s2_first_q, s2_last_q, s2_phase_q;
  logic [AW-1:0] s1_wa_q, s2_wa_q;
  logic signed [BW-1:0] op1;
  logic signed [EW-1:0] op2;
  logic signed [RW-1:0] prod_q, acc_q, acc_d;

  // Addresses: A row-major, B and C column-major
  assign idx_addr = AW'(32'(element_index_i));
  assign ik_w = PW'(i_i) * PW'(n_i) + PW'(k_i);
  assign kj_w = PW'(j_i) * PW'(n_i) + PW'(k_i);
  assign ij_w = PW'(i_i) * PW'(n_i) + PW'(j_i);
  assign ik_addr = ik_w[AW-1:0];
  assign kj_addr = kj_w[AW-1:0];
  assign ij_addr = ij_w[AW-1:0];

  // Operand memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_a) begin
      mem_a[idx_addr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      a_rd_q <= mem_a[ik_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_b) begin
      mem_b[idx_addr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      b_rd_q <= mem_b[kj_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_c) begin
      mem_c[idx_addr] <= element_value_i;
    end
    if (cmd_i.issue) begin
      c_rd_q <= mem_c[kj_addr];
    end
  end

  // AB store
  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_last_q && !s2_phase_q) begin
      mem_p[s2_wa_q] <= tmp_pkg::sat48(acc_d);
    end
    if (cmd_i.issue) begin
      p_rd_q <= mem_p[ik_addr];
    end
  end

  // ABC store
  always_ff @(posedge clk_i) begin
    if (s2_vld_q && s2_last_q && s2_phase_q) begin
      mem_f[s2_wa_q] <= acc_d;
    end
    if (cmd_i.rd_res) begin
      f_rd_q <= mem_f[idx_addr];
    end
  end

  // Shared multiplier, operands by phase
  assign op1 = s1_phase_q ? p_rd_q : BW'(a_rd_q);
  assign op2 = s1_phase_q ? c_rd_q : b_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= RW'(op1) * RW'(op2);
    s1_first_q <= cmd_i.first;
    s1_last_q <= cmd_i.last;
    s1_phase_q <= cmd_i.phase;
    s1_wa_q <= ij_addr;
    s2_first_q <= s1_first_q;
    s2_last_q <= s1_last_q;
    s2_phase_q <= s1_phase_q;
    s2_wa_q <= s1_wa_q;
  end

  // Accumulator, clamped at each add
  assign acc_d = s2_first_q ? prod_q : tmp_pkg::sat_add64(acc_q, prod_q);

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (cmd_i.val_load) begin
      val_q <= cmd_i.val_mem ? f_rd_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  assign read_value_o = val_q;

endmodule

// ===== rtl/core/triple_matrix_product.sv =====
// Load, read-out-of-range and status-only items: result one cycle after accept.
// Read of a computed element: result two cycles after accept (registered ABC memory read).
// Compute item: one multiply-accumulate per cycle through a single
// shared multiplier and a three-stage read/multiply/accumulate pipeline.
// Throughput: one item in flight; the next item is taken in the cycle its result is taken.
// Reset (rst_ni low, async): size back to 64, no result ready, output empty;
// the matrix memories are not cleared.
module triple_matrix_product #(
  parameter int unsigned MAX_SIZE = tmp_pkg::MaxSizeDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tmp_pkg::SizeW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic [tmp_pkg::OpW-1:0] opcode_i,
  input  logic [tmp_pkg::IdxW-1:0] element_index_i,
  input  logic signed [tmp_pkg::ElemW-1:0] element_value_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [tmp_pkg::ResW-1:0] read_value_o,
  output logic [tmp_pkg::StatW-1:0] status_o
);

  localparam int unsigned SW = $clog2(MAX_SIZE + 1);
  localparam int unsigned IW = $clog2(MAX_SIZE);

  tmp_pkg::cmd_t cmd;
  logic [SW-1:0] n;
  logic [IW-1:0] i, j, k;

  tmp_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .opcode_i, .element_index_i,
    .out_valid_o, .out_ready_i, .status_o,
    .cmd_o(cmd), .n_o(n), .i_o(i), .j_o(j), .k_o(k)
  );

  tmp_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .n_i(n), .i_i(i), .j_i(j), .k_i(k),
    .element_index_i, .element_value_i, .read_value_o
  );

endmodule

// ===== rtl/core/tmp_checker.sv =====
module tmp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic [tmp_pkg::OpW-1:0] opcode_i,
  input logic signed [tmp_pkg::ResW-1:0] read_value_o,
  input logic [tmp_pkg::StatW-1:0] status_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) && $stable(status_o))
    else $error("result changed while stalled");

  // status code three never appears
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != tmp_pkg::StUnused)
    else $error("unused status code");

  // only a good read carries a value
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != tmp_pkg::StOk |-> read_value_o == '0)
    else $error("value on failed item");

  // a compute item holds off the next item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && opcode_i == tmp_pkg::OpCompute |=> !in_ready_o)
    else $error("accepted during compute");

endmodule

bind triple_matrix_product tmp_checker u_tmp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_ready_i, .in_valid_i, .in_ready_o,
  .opcode_i, .read_value_o, .status_o
);
